// ----- rtl/hid_boot_keyboard_report_to_ascii_core_defines.svh -----
// Assertion macros for the HID boot-keyboard to ASCII core.
// Standalone header; expects clk and rst_n in the scope of each use.
`ifndef HID_BOOT_KEYBOARD_REPORT_TO_ASCII_CORE_DEFINES_SVH
`define HID_BOOT_KEYBOARD_REPORT_TO_ASCII_CORE_DEFINES_SVH

// Check that cond holds in the same cycle as trig.
`define HBK_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check that cond holds in the cycle after trig.
`define HBK_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- rtl/hbk_pkg.sv -----
// Shared types, constants and keymap functions for the HID keyboard core.
// No dependencies.
package hbk_pkg;

    localparam int KEY_SLOTS     = 6;
    localparam int SLOT_IDX_W    = $clog2(KEY_SLOTS);
    localparam logic [7:0] SHIFT_MASK = 8'h22;
    localparam logic [6:0] ESC_CODE   = 7'h1B;
    localparam logic [3:0] MIN_LENGTH = 4'd3;

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
        logic [3:0] report_length;
    } report_t;

    typedef struct packed {
        logic [6:0] ascii_char;
        logic       last_of_run;
    } ascii_t;

    // What one lane found for its slot.
    typedef struct packed {
        logic       emit;
        logic [6:0] ch;
    } lane_result_t;

    // Unshifted US-QWERTY map; zero means no character.
    function automatic logic [6:0] plain_char(input logic [6:0] u);
        logic [6:0] c;
        c = 7'h00;
        if (u >= 7'd4 && u <= 7'd29) begin
            c = (u - 7'd4) + 7'h61;
        end else if (u >= 7'd30 && u <= 7'd38) begin
            c = (u - 7'd30) + 7'h31;
        end else if (u >= 7'd89 && u <= 7'd97) begin
            c = (u - 7'd89) + 7'h31;
        end else begin
            unique case (u)
                7'd39:   c = 7'h30;
                7'd40:   c = 7'h0A;
                7'd41:   c = ESC_CODE;
                7'd42:   c = 7'h08;
                7'd43:   c = 7'h09;
                7'd44:   c = 7'h20;
                7'd45:   c = 7'h2D;
                7'd46:   c = 7'h3D;
                7'd47:   c = 7'h5B;
                7'd48:   c = 7'h5D;
                7'd49:   c = 7'h5C;
                7'd51:   c = 7'h3B;
                7'd52:   c = 7'h27;
                7'd53:   c = 7'h60;
                7'd54:   c = 7'h2C;
                7'd55:   c = 7'h2E;
                7'd56:   c = 7'h2F;
                7'd84:   c = 7'h2F;
                7'd85:   c = 7'h2A;
                7'd86:   c = 7'h2D;
                7'd87:   c = 7'h2B;
                7'd88:   c = 7'h0A;
                7'd98:   c = 7'h30;
                7'd99:   c = 7'h2E;
                default: c = 7'h00;
            endcase
        end
        return c;
    endfunction

    // Shifted US-QWERTY map; zero falls back to the unshifted entry.
    function automatic logic [6:0] shifted_char(input logic [6:0] u);
        logic [6:0] c;
        c = 7'h00;
        if (u >= 7'd4 && u <= 7'd29) begin
            c = (u - 7'd4) + 7'h41;
        end else begin
            unique case (u)
                7'd30:   c = 7'h21;
                7'd31:   c = 7'h40;
                7'd32:   c = 7'h23;
                7'd33:   c = 7'h24;
                7'd34:   c = 7'h25;
                7'd35:   c = 7'h5E;
                7'd36:   c = 7'h26;
                7'd37:   c = 7'h2A;
                7'd38:   c = 7'h28;
                7'd39:   c = 7'h29;
                7'd40:   c = 7'h0A;
                7'd41:   c = ESC_CODE;
                7'd42:   c = 7'h08;
                7'd43:   c = 7'h09;
                7'd44:   c = 7'h20;
                7'd45:   c = 7'h5F;
                7'd46:   c = 7'h2B;
                7'd47:   c = 7'h7B;
                7'd48:   c = 7'h7D;
                7'd49:   c = 7'h7C;
                7'd51:   c = 7'h3A;
                7'd52:   c = 7'h22;
                7'd53:   c = 7'h7E;
                7'd54:   c = 7'h3C;
                7'd55:   c = 7'h3E;
                7'd56:   c = 7'h3F;
                default: c = 7'h00;
            endcase
        end
        return c;
    endfunction

endpackage

// ----- rtl/hbk_lane.sv -----
// One key-slot lane: filters a usage and maps it to ASCII.
// Depends on hbk_pkg.
module hbk_lane
    import hbk_pkg::*;
(
    input  logic [7:0]                 usage,
    input  logic                       shift,
    input  logic                       slot_valid,
    input  logic [KEY_SLOTS-1:0][7:0]  last_keys,
    output lane_result_t               result
);

    logic       key_held;
    logic [6:0] shifted;
    logic [6:0] plain;
    logic [6:0] ch;

    always_comb
    begin
        key_held = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++)
        begin
            if (last_keys[j] == usage)
            begin
                key_held = 1'b1;
            end
        end
    end

    assign shifted = shifted_char(usage[6:0]);
    assign plain   = plain_char(usage[6:0]);
    assign ch      = (shift && shifted != 7'h00) ? shifted : plain;

    // Drop empty, out-of-range, still-held and unmapped usages, and slots past the length.
    assign result.ch   = ch;
    assign result.emit = slot_valid && usage != 8'h00 && !usage[7] && !key_held
                         && ch != 7'h00;

endmodule

// ----- rtl/hbk_serializer.sv -----
// Merge stage: holds one report's lane results and sends them out one per cycle unless out_stall holds them.
// Depends on hbk_pkg.
module hbk_serializer
    import hbk_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  lane_result_t [KEY_SLOTS-1:0]      lanes,
    output logic                              ready,
    output logic                              out_valid,
    input  logic                              out_stall,
    output ascii_t                            out_data
);

    logic [KEY_SLOTS-1:0]  pend_reg;
    logic [KEY_SLOTS-1:0]  pend_next;
    logic [6:0]            char_reg [KEY_SLOTS];
    logic                  out_valid_reg;
    logic                  out_valid_next;
    ascii_t                out_data_reg;
    ascii_t                out_data_next;

    logic                  out_free;
    logic                  pop;
    logic [SLOT_IDX_W-1:0] sel;
    logic [KEY_SLOTS-1:0]  rest;
    logic [KEY_SLOTS-1:0]  new_mask;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = out_free && (pend_reg != '0);

    // Lowest pending slot goes first.
    always_comb
    begin
        sel = '0;
        for (int i = KEY_SLOTS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                sel = SLOT_IDX_W'(i);
            end
        end
        rest      = pend_reg;
        rest[sel] = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            new_mask[i] = lanes[i].emit;
        end
    end

    assign ready = (pend_reg == '0) || (pop && rest == '0);

    always_comb
    begin
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            pend_next                 = rest;
            out_valid_next            = 1'b1;
            out_data_next.ascii_char  = char_reg[sel];
            out_data_next.last_of_run = (rest == '0);
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            pend_next = new_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (load)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                char_reg[i] <= lanes[i].ch;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/hid_boot_keyboard_report_to_ascii_core.sv -----
// Top level of the HID boot-keyboard report to ASCII converter.
// Depends on hbk_pkg, hbk_lane, hbk_serializer and the assertion macro header.
//
//  channel  | dir | handshake                   | payload
//  ---------+-----+-----------------------------+-----------------------
//  report   | in  | report_valid / report_stall | report_data (report_t)
//  ascii    | out | ascii_valid  / ascii_stall  | ascii_data  (ascii_t)
//
// A report is taken when report_valid is high and report_stall low: six lanes
// check their slots against the previous-key store and the merge stage latches
// what they found; from there the characters move to the output register.
// Characters leave one per cycle unless ascii_stall holds them, so a report gives
// 0 to 6 characters; the next report is taken in the cycle the last one moves to
// the output register, at once for a short or empty report. Reset clears the
// store, the pending mask and the output valid. An ascii stall on a valid output
// holds it and the mask, so report_stall stays high while characters are pending.
`include "hid_boot_keyboard_report_to_ascii_core_defines.svh"

module hid_boot_keyboard_report_to_ascii_core
    import hbk_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    report_valid,
    output logic    report_stall,
    input  report_t report_data,
    output logic    ascii_valid,
    input  logic    ascii_stall,
    output ascii_t  ascii_data
);

    logic [KEY_SLOTS-1:0][7:0] last_keys_reg;
    logic [KEY_SLOTS-1:0][7:0] last_keys_next;
    logic [KEY_SLOTS-1:0][7:0] keys;
    logic [KEY_SLOTS-1:0]      slot_valid;
    lane_result_t [KEY_SLOTS-1:0] lanes;

    logic accept;
    logic long_enough;
    logic load;
    logic shift;
    logic ready;

    assign keys[0] = report_data.key_slot_0;
    assign keys[1] = report_data.key_slot_1;
    assign keys[2] = report_data.key_slot_2;
    assign keys[3] = report_data.key_slot_3;
    assign keys[4] = report_data.key_slot_4;
    assign keys[5] = report_data.key_slot_5;

    assign shift        = (report_data.modifier_bits & SHIFT_MASK) != 8'h00;
    assign long_enough  = report_data.report_length >= MIN_LENGTH;
    assign report_stall = !ready;
    assign accept       = report_valid && !report_stall;
    // Short reports are consumed but change nothing.
    assign load         = accept && long_enough;

    for (genvar i = 0; i < KEY_SLOTS; i++)
    begin : g_lane
        // Slot i sits in byte i + 2 and is covered when the length is at least i + 3.
        assign slot_valid[i] = report_data.report_length >= 4'(i + 3);

        hbk_lane u_lane (
            .usage      (keys[i]),
            .shift      (shift),
            .slot_valid (slot_valid[i]),
            .last_keys  (last_keys_reg),
            .result     (lanes[i])
        );

        // Reload the store, zero past the length.
        assign last_keys_next[i] = slot_valid[i] ? keys[i] : 8'h00;
    end

    hbk_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .lanes     (lanes),
        .ready     (ready),
        .out_valid (ascii_valid),
        .out_stall (ascii_stall),
        .out_data  (ascii_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_keys_reg <= '0;
        end
        else if (load)
        begin
            last_keys_reg <= last_keys_next;
        end
    end

    `HBK_ASSERT_NEXT(a_short_keeps_store, accept && !long_enough, $stable(last_keys_reg),
        "short report changed the previous-key store")
    `HBK_ASSERT_NEXT(a_store_slot0, load, last_keys_reg[0] == $past(keys[0]),
        "previous-key store not reloaded from slot 0")
    `HBK_ASSERT_SAME(a_char_nonzero, ascii_valid, ascii_data.ascii_char != 7'h00,
        "zero character presented on the output")

endmodule

// ----- sim/tb_hid_boot_keyboard_report_to_ascii_core.sv -----
// Self-checking testbench for the HID boot-keyboard report to ASCII core.
// Depends on hbk_pkg and hid_boot_keyboard_report_to_ascii_core.
// Predicts characters per report and checks every ascii transaction in order.
module tb_hid_boot_keyboard_report_to_ascii_core;
    import hbk_pkg::*;

    // Give up after this many cycles with no transaction on either channel.
    localparam int QUIET_LIMIT = 5000;
    // Cycles to keep watching after the last expected character.
    localparam int DRAIN_TAIL  = 20;
    // Length of the receiver hold-off in the back-pressure test.
    localparam int HOLD_CYCLES = 200;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    report_valid = 1'b0;
    logic    report_stall;
    report_t report_data = '0;
    logic    ascii_valid;
    logic    ascii_stall = 1'b0;
    ascii_t  ascii_data;

    // Characters predicted for accepted reports, oldest first.
    ascii_t     expected_chars [$];
    // Predictor copy of the previous-key store.
    logic [7:0] held_keys [KEY_SLOTS];
    ascii_t     oldest_char;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_req  = 0;
    int mismatches    = 0;

    hid_boot_keyboard_report_to_ascii_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report_data  (report_data),
        .ascii_valid  (ascii_valid),
        .ascii_stall  (ascii_stall),
        .ascii_data   (ascii_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // US-QWERTY lookup: shifted entry when shift is held and the entry exists,
    // otherwise the plain entry. Zero means the usage has no character.
    function automatic logic [6:0] qwerty_ascii(input logic [6:0] u, input bit shift);
        logic [7:0] plain;
        logic [7:0] upper;
        plain = 8'h00;
        upper = 8'h00;
        if (u >= 4 && u <= 29)
            plain = {1'b0, u} + 8'h5D;
        else if (u >= 30 && u <= 38)
            plain = {1'b0, u} + 8'h13;
        else if (u >= 89 && u <= 97)
            plain = {1'b0, u} - 8'd40;
        else
        begin
            case (u)
                39, 98:  plain = "0";
                40, 88:  plain = 8'h0A;
                41:      plain = {1'b0, ESC_CODE};
                42:      plain = 8'h08;
                43:      plain = 8'h09;
                44:      plain = " ";
                45, 86:  plain = "-";
                46:      plain = "=";
                47:      plain = "[";
                48:      plain = "]";
                49:      plain = 8'h5C;
                51:      plain = ";";
                52:      plain = 8'h27;
                53:      plain = 8'h60;
                54:      plain = ",";
                55, 99:  plain = ".";
                56, 84:  plain = "/";
                85:      plain = "*";
                87:      plain = "+";
                default: plain = 8'h00;
            endcase
        end
        if (u >= 4 && u <= 29)
            upper = {1'b0, u} + 8'h3D;
        else
        begin
            case (u)
                30:      upper = "!";
                31:      upper = "@";
                32:      upper = "#";
                33:      upper = "$";
                34:      upper = "%";
                35:      upper = "^";
                36:      upper = "&";
                37:      upper = "*";
                38:      upper = "(";
                39:      upper = ")";
                40:      upper = 8'h0A;
                41:      upper = {1'b0, ESC_CODE};
                42:      upper = 8'h08;
                43:      upper = 8'h09;
                44:      upper = " ";
                45:      upper = "_";
                46:      upper = "+";
                47:      upper = "{";
                48:      upper = "}";
                49:      upper = "|";
                51:      upper = ":";
                52:      upper = 8'h22;
                53:      upper = "~";
                54:      upper = "<";
                55:      upper = ">";
                56:      upper = "?";
                default: upper = 8'h00;
            endcase
        end
        return (shift && upper != 8'h00) ? upper[6:0] : plain[6:0];
    endfunction

    // Work out the characters one accepted report causes, queue them and
    // reload the previous-key store.
    task automatic predict_report(input report_t r);
        logic [7:0] slot_usage [KEY_SLOTS];
        logic [6:0] found [KEY_SLOTS];
        logic [6:0] ch;
        ascii_t     item;
        bit         shift;
        bit         key_held;
        int         live;
        int         n;
        int         i;
        int         j;
        slot_usage[0] = r.key_slot_0;
        slot_usage[1] = r.key_slot_1;
        slot_usage[2] = r.key_slot_2;
        slot_usage[3] = r.key_slot_3;
        slot_usage[4] = r.key_slot_4;
        slot_usage[5] = r.key_slot_5;
        // Short report: drop it and leave the store alone.
        if (r.report_length < MIN_LENGTH)
            return;
        if (r.report_length > 4'd8)
            live = KEY_SLOTS;
        else
            live = r.report_length - 2;
        shift = (r.modifier_bits & SHIFT_MASK) != 8'h00;
        n = 0;
        for (i = 0; i < live; i++)
        begin
            // Usage zero and the upper half of the range never emit.
            if (slot_usage[i] == 8'h00 || slot_usage[i][7])
                continue;
            key_held = 1'b0;
            for (j = 0; j < KEY_SLOTS; j++)
                if (held_keys[j] == slot_usage[i])
                    key_held = 1'b1;
            if (key_held)
                continue;
            ch = qwerty_ascii(slot_usage[i][6:0], shift);
            if (ch == 7'h00)
                continue;
            found[n] = ch;
            n++;
        end
        for (i = 0; i < n; i++)
        begin
            item.ascii_char  = found[i];
            item.last_of_run = (i == n - 1);
            expected_chars.push_back(item);
        end
        for (i = 0; i < KEY_SLOTS; i++)
            held_keys[i] = (i < live) ? slot_usage[i] : 8'h00;
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    function automatic report_t make_report(input logic [7:0] mods,
                                            input logic [7:0] k0, input logic [7:0] k1,
                                            input logic [7:0] k2, input logic [7:0] k3,
                                            input logic [7:0] k4, input logic [7:0] k5,
                                            input logic [3:0] len);
        report_t r;
        r.modifier_bits = mods;
        r.key_slot_0    = k0;
        r.key_slot_1    = k1;
        r.key_slot_2    = k2;
        r.key_slot_3    = k3;
        r.key_slot_4    = k4;
        r.key_slot_5    = k5;
        r.report_length = len;
        return r;
    endfunction

    // Offer one report, idling first at random, and return in the time step
    // of the edge that accepted it.
    task automatic send_report(input report_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            report_valid <= 1'b0;
            @(posedge clk);
        end
        report_valid <= 1'b1;
        report_data  <= r;
        @(posedge clk);
        while (report_stall)
            @(posedge clk);
        predict_report(r);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    // Receiver: stall at random, or hold off for a counted stretch on request.
    initial
    begin : ascii_receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req != 0)
            begin
                hold_left    = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ascii_stall <= 1'b1;
            end
            else
                ascii_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %0h want %0h", what, got, want);
        mismatches++;
    endtask

    // Compare every accepted ascii transaction with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && ascii_valid && !ascii_stall)
        begin
            if (expected_chars.size() == 0)
                report_mismatch("ascii transaction with nothing expected",
                                32'(ascii_data.ascii_char), 32'd0);
            else
            begin
                oldest_char = expected_chars.pop_front();
                if (ascii_data.ascii_char !== oldest_char.ascii_char)
                    report_mismatch("ascii_char", 32'(ascii_data.ascii_char),
                                    32'(oldest_char.ascii_char));
                if (ascii_data.last_of_run !== oldest_char.last_of_run)
                    report_mismatch("last_of_run", 32'(ascii_data.last_of_run),
                                    32'(oldest_char.last_of_run));
            end
        end
    end

    // Watchdog: count cycles with no transaction on either channel.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((report_valid && !report_stall) || (ascii_valid && !ascii_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_hid_boot_keyboard_report_to_ascii_core failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Full six-key report, the same keys again, then release everything.
    task automatic test_key_rollover();
        send_report(make_report(8'h00, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 4'd8));
        send_report(make_report(8'h00, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 4'd8));
        send_report(make_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'd8));
    endtask

    // Short reports must not emit nor touch the store: the final report
    // repeats the held keys and so must emit nothing.
    task automatic test_short_reports();
        send_report(make_report(8'h00, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 4'd8));
        send_report(make_report(8'h00, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 4'd2));
        send_report(make_report(8'h22, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 4'd1));
        send_report(make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd0));
        send_report(make_report(8'h00, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 4'd8));
    endtask

    // Length above eight, a minimal length with junk past it, and a report
    // that then finds those slots stored as zero.
    task automatic test_length_and_past_slots();
        send_report(make_report(8'h02, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 4'd15));
        send_report(make_report(8'h20, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 4'd3));
        send_report(make_report(8'h00, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 4'd9));
    endtask

    // Both shift bits, fallback to the plain table, control keys, and
    // modifiers with every bit but the shifts set.
    task automatic test_shift_and_fallback();
        send_report(make_report(8'h22, 8'd84, 8'd89, 8'd56, 8'd53, 8'd57, 8'd4, 4'd8));
        send_report(make_report(8'hDD, 8'd40, 8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 4'd8));
        send_report(make_report(8'hFF, 8'd49, 8'd52, 8'd47, 8'd48, 8'd51, 8'd99, 4'd8));
        send_report(make_report(8'h00, 8'd46, 8'd54, 8'd55, 8'd85, 8'd87, 8'd98, 4'd8));
    endtask

    // Ignored usages, usages with no character, and repeats inside one report.
    task automatic test_ignored_and_repeated();
        send_report(make_report(8'h00, 8'h80, 8'hFF, 8'h00, 8'd50, 8'd100, 8'd127, 4'd8));
        send_report(make_report(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd8));
        send_report(make_report(8'h00, 8'd20, 8'd20, 8'd20, 8'h80, 8'd20, 8'd7, 4'd7));
        send_report(make_report(8'h00, 8'd20, 8'd7, 8'd0, 8'd0, 8'd0, 8'd0, 4'd4));
    endtask

    // Typing-like reports: keys held over from the previous report, new
    // keys from the mapped range, and some noise and odd lengths.
    task automatic test_random_typing(input int count);
        logic [7:0] prior [KEY_SLOTS];
        logic [7:0] fresh [KEY_SLOTS];
        logic [7:0] mods;
        logic [3:0] len;
        int         pick;
        int         n;
        int         i;
        for (i = 0; i < KEY_SLOTS; i++)
            prior[i] = 8'h00;
        for (n = 0; n < count; n++)
        begin
            for (i = 0; i < KEY_SLOTS; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                    fresh[i] = prior[i];
                else if (pick < 38)
                    fresh[i] = prior[$urandom_range(KEY_SLOTS - 1)];
                else if (pick < 78)
                    fresh[i] = 8'($urandom_range(56, 4));
                else if (pick < 85)
                    fresh[i] = 8'($urandom_range(99, 84));
                else if (pick < 91)
                    fresh[i] = 8'h00;
                else if (pick < 95)
                    fresh[i] = 8'($urandom_range(255, 128));
                else
                    fresh[i] = 8'($urandom_range(255));
            end
            mods = 8'($urandom_range(255));
            if ($urandom_range(99) < 40)
                mods = mods & ~SHIFT_MASK;
            pick = $urandom_range(99);
            if (pick < 70)
                len = 4'd8;
            else if (pick < 85)
                len = 4'($urandom_range(7, 3));
            else if (pick < 93)
                len = 4'($urandom_range(15, 9));
            else
                len = 4'($urandom_range(2));
            send_report(make_report(mods, fresh[0], fresh[1], fresh[2], fresh[3],
                                    fresh[4], fresh[5], len));
            for (i = 0; i < KEY_SLOTS; i++)
                prior[i] = fresh[i];
        end
    endtask

    // Hold the receiver off for a long stretch while reports keep coming,
    // so the core fills up and stalls the report channel.
    task automatic test_receiver_hold_off();
        int n;
        hold_off_req = HOLD_CYCLES;
        for (n = 0; n < 12; n++)
        begin
            if (n % 2 == 0)
                send_report(make_report(8'h00, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 4'd8));
            else
                send_report(make_report(8'h02, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15,
                                        4'd8));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin : main_sequence
        int i;
        for (i = 0; i < KEY_SLOTS; i++)
            held_keys[i] = 8'h00;
        // Hold reset, then release it once for good.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles rarely, receiver stalls often.
        set_idling(12, 77);
        test_key_rollover();
        test_short_reports();
        test_length_and_past_slots();
        test_shift_and_fallback();
        test_ignored_and_repeated();
        test_random_typing(30);

        // Sender idles often, receiver stalls rarely.
        set_idling(77, 12);
        test_random_typing(30);

        // No idling on either side.
        set_idling(0, 0);
        test_receiver_hold_off();
        test_random_typing(30);

        // Drop valid, drain the outstanding characters, then watch a while.
        report_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (mismatches == 0)
            $display("tb_hid_boot_keyboard_report_to_ascii_core passed");
        else
            $display("tb_hid_boot_keyboard_report_to_ascii_core failed");
        $finish;
    end

endmodule
